>>> rtl/core/cdt_pkg.sv
// Shared types, codes and helpers for the countdown timer controller.
package cdt_pkg;

  localparam int unsigned Digits = 4;
  localparam logic [13:0] MaxCount = 14'd9999;
  localparam logic [2:0]  DigitNone = 3'(Digits);

  // input event codes
  localparam logic [2:0] CmdTick  = 3'd0;
  localparam logic [2:0] CmdStop  = 3'd1;
  localparam logic [2:0] CmdStart = 3'd2;
  localparam logic [2:0] CmdPush  = 3'd3;
  localparam logic [2:0] CmdEdgeA = 3'd4;
  localparam logic [2:0] CmdEdgeB = 3'd5;

  // reported run state codes
  localparam logic [1:0] RsRun   = 2'd0;
  localparam logic [1:0] RsStop  = 2'd1;
  localparam logic [1:0] RsClear = 2'd2;
  localparam logic [1:0] RsOff   = 2'd3;

  // direction lamp codes
  localparam logic [1:0] LampDark = 2'd0;
  localparam logic [1:0] LampUp   = 2'd1;
  localparam logic [1:0] LampDown = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CfgPeriod  = 3'd0;
  localparam logic [2:0] CfgBeepOn  = 3'd1;
  localparam logic [2:0] CfgBeepOff = 3'd2;
  localparam logic [2:0] CfgGuard   = 3'd3;
  localparam logic [2:0] CfgLamp    = 3'd4;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_TICK,
    EV_STOP,
    EV_START,
    EV_PUSH,
    EV_EDGE_A,
    EV_EDGE_B
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e kind;
    logic     lvl;
  } ev_t;

  typedef enum logic [3:0] {
    RUN_S   = 4'b0001,
    STOP_S  = 4'b0010,
    CLEAR_S = 4'b0100,
    OFF_S   = 4'b1000
  } run_e;

  typedef enum logic [2:0] {
    BEEP_ON   = 3'b001,
    BEEP_GAP  = 3'b010,
    BEEP_IDLE = 3'b100
  } beep_e;

  function automatic logic [13:0] digit_weight(input logic [1:0] d);
    logic [13:0] w;
    case (d)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic logic [9:0] min_one10(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [7:0] min_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

>>> rtl/core/cdt_front.sv
// Front end: accepts input beats and classifies them into events.
module cdt_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      cmd_i,
  input  logic            pin_level_i,
  input  logic            full_i,
  output logic            push_o,
  output cdt_pkg::ev_t    ev_o
);
  import cdt_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    ev_o.lvl = pin_level_i;
    unique case (cmd_i)
      CmdTick:  ev_o.kind = EV_TICK;
      // button releases do nothing but still report state
      CmdStop:  ev_o.kind = pin_level_i ? EV_NONE : EV_STOP;
      CmdStart: ev_o.kind = pin_level_i ? EV_NONE : EV_START;
      CmdPush:  ev_o.kind = EV_PUSH;
      CmdEdgeA: ev_o.kind = EV_EDGE_A;
      CmdEdgeB: ev_o.kind = EV_EDGE_B;
      default:  ev_o.kind = EV_NONE;
    endcase
  end

endmodule

>>> rtl/core/cdt_queue.sv
// Small event queue between the front end and the executor.
module cdt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cdt_pkg::ev_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         pop_valid_o,
  output cdt_pkg::ev_t pop_data_o
);
  import cdt_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ev_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntW'(DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/cdt_exec.sv
// Executor: one event per cycle unless stalled; holds timer state, config and result.
module cdt_exec (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [9:0]   cfg_wdata_i,
  input  logic         ev_valid_i,
  input  cdt_pkg::ev_t ev_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [13:0]  count_value_o,
  output logic [1:0]   run_state_o,
  output logic [2:0]   adjust_digit_o,
  output logic         beeper_on_o,
  output logic [1:0]   dir_lamp_o
);
  import cdt_pkg::*;

  // configuration
  logic [9:0] cfg_period_q;
  logic [7:0] cfg_on_q, cfg_off_q, cfg_guard_q, cfg_lamp_q;

  // timer state
  logic [13:0] count_q, count_d;
  run_e        run_q, run_d;
  logic [2:0]  digit_q, digit_d;
  logic        lvl_a_q, lvl_a_d, lvl_b_q, lvl_b_d;
  logic        pend_a_q, pend_a_d, pend_b_q, pend_b_d;
  beep_e       beep_q, beep_d;
  logic [2:0]  beep_left_q, beep_left_d;
  logic [7:0]  beep_ms_q, beep_ms_d;
  logic [9:0]  period_q, period_d;
  logic [1:0]  lamp_q, lamp_d;
  logic [7:0]  lamp_ms_q, lamp_ms_d;
  logic [7:0]  since_q, since_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [13:0] o_count_q;
  logic [1:0]  o_run_q;
  logic [2:0]  o_digit_q;
  logic        o_beep_q;
  logic [1:0]  o_lamp_q;

  logic take;

  assign take  = ev_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = take;

  function automatic logic [1:0] run_code(input run_e r);
    logic [1:0] c;
    unique case (r)
      RUN_S:   c = RsRun;
      STOP_S:  c = RsStop;
      CLEAR_S: c = RsClear;
      default: c = RsOff;
    endcase
    return c;
  endfunction

  always_comb begin
    logic        beep_one;
    logic        step;
    logic        step_up;
    logic        tick_start;
    beep_e       ph;
    logic [2:0]  left;
    logic [7:0]  ms;
    logic [7:0]  ms_nx;
    logic [2:0]  left_nx;
    logic [9:0]  per_nx;
    logic [7:0]  lamp_nx;
    logic [13:0] w;
    logic [14:0] sum;

    count_d     = count_q;
    run_d       = run_q;
    digit_d     = digit_q;
    lvl_a_d     = lvl_a_q;
    lvl_b_d     = lvl_b_q;
    pend_a_d    = pend_a_q;
    pend_b_d    = pend_b_q;
    beep_d      = beep_q;
    beep_left_d = beep_left_q;
    beep_ms_d   = beep_ms_q;
    period_d    = period_q;
    lamp_d      = lamp_q;
    lamp_ms_d   = lamp_ms_q;
    since_d     = since_q;

    beep_one   = 1'b0;
    step       = 1'b0;
    step_up    = 1'b0;
    tick_start = 1'b0;
    ph         = beep_q;
    left       = beep_left_q;
    ms         = beep_ms_q;
    ms_nx      = '0;
    left_nx    = '0;
    per_nx     = '0;
    lamp_nx    = '0;
    w          = digit_weight(digit_q[1:0]);
    sum        = {1'b0, count_q} + {1'b0, w};

    if (take) begin
      unique case (ev_i.kind)
        EV_TICK: begin
          if (since_q != 8'hFF) begin
            since_d = since_q + 8'd1;
          end
          if (run_q == RUN_S) begin
            if (count_q == '0) begin
              run_d      = STOP_S;
              tick_start = 1'b1;
            end else begin
              per_nx = period_q + 10'd1;
              if (per_nx >= min_one10(cfg_period_q)) begin
                period_d = '0;
                count_d  = count_q - 14'd1;
                if (count_q == 14'd1) begin
                  run_d      = STOP_S;
                  tick_start = 1'b1;
                end
              end else begin
                period_d = per_nx;
              end
            end
          end
          // reaching zero starts a four-pulse sequence, then it advances this tick
          if (tick_start) begin
            ph   = BEEP_ON;
            left = 3'd4;
            ms   = '0;
          end
          ms_nx   = ms + 8'd1;
          left_nx = left - 3'd1;
          if (ph == BEEP_ON) begin
            if (ms_nx >= min_one8(cfg_on_q)) begin
              beep_ms_d   = '0;
              beep_left_d = left_nx;
              beep_d      = (left_nx == '0) ? BEEP_IDLE : BEEP_GAP;
            end else begin
              beep_ms_d   = ms_nx;
              beep_left_d = left;
              beep_d      = ph;
            end
          end else if (ph == BEEP_GAP) begin
            beep_left_d = left;
            if (ms_nx >= min_one8(cfg_off_q)) begin
              beep_ms_d = '0;
              beep_d    = BEEP_ON;
            end else begin
              beep_ms_d = ms_nx;
              beep_d    = ph;
            end
          end
          if (lamp_q != LampDark) begin
            lamp_nx = lamp_ms_q + 8'd1;
            if (lamp_nx >= min_one8(cfg_lamp_q)) begin
              lamp_ms_d = '0;
              lamp_d    = LampDark;
            end else begin
              lamp_ms_d = lamp_nx;
            end
          end
        end
        EV_STOP: begin
          unique case (run_q)
            RUN_S: begin
              run_d    = STOP_S;
              beep_one = 1'b1;
            end
            STOP_S: begin
              beep_one = 1'b1;
              if (count_q != '0) begin
                run_d   = CLEAR_S;
                count_d = '0;
              end else begin
                digit_d = DigitNone;
                run_d   = OFF_S;
              end
            end
            CLEAR_S: begin
              digit_d  = DigitNone;
              run_d    = OFF_S;
              beep_one = 1'b1;
            end
            default: begin
            end
          endcase
        end
        EV_START: begin
          if (run_q != RUN_S && count_q != '0) begin
            digit_d  = DigitNone;
            period_d = '0;
            run_d    = RUN_S;
            beep_one = 1'b1;
          end
        end
        EV_PUSH: begin
          if (since_q >= cfg_guard_q && !ev_i.lvl &&
              (run_q == STOP_S || run_q == CLEAR_S)) begin
            digit_d = (digit_q >= DigitNone) ? 3'd0 : digit_q + 3'd1;
          end
          since_d = '0;
        end
        EV_EDGE_A: begin
          lvl_a_d = ev_i.lvl;
          if (pend_b_q) begin
            if (ev_i.lvl == lvl_b_q) begin
              step     = 1'b1;
              pend_a_d = 1'b0;
              pend_b_d = 1'b0;
            end else begin
              pend_b_d = 1'b0;
              pend_a_d = 1'b1;
            end
          end else begin
            pend_a_d = 1'b1;
          end
        end
        EV_EDGE_B: begin
          lvl_b_d = ev_i.lvl;
          step_up = 1'b1;
          if (pend_a_q) begin
            if (lvl_a_q == ev_i.lvl) begin
              step     = 1'b1;
              pend_a_d = 1'b0;
              pend_b_d = 1'b0;
            end else begin
              pend_a_d = 1'b0;
              pend_b_d = 1'b1;
            end
          end else begin
            pend_b_d = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // completed quadrature step: A then B counts up, B then A counts down
      if (step) begin
        lamp_d    = step_up ? LampUp : LampDown;
        lamp_ms_d = '0;
        if (digit_q < DigitNone) begin
          if (step_up) begin
            if (sum <= {1'b0, MaxCount}) begin
              count_d = sum[13:0];
            end
          end else if (count_q >= w) begin
            count_d = count_q - w;
          end
        end
        if (run_q == RUN_S) begin
          beep_one = 1'b1;
        end
        run_d = STOP_S;
      end

      if (beep_one) begin
        beep_d      = BEEP_ON;
        beep_left_d = 3'd1;
        beep_ms_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_period_q <= 10'd2;
      cfg_on_q     <= 8'd200;
      cfg_off_q    <= 8'd200;
      cfg_guard_q  <= 8'd50;
      cfg_lamp_q   <= 8'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPeriod:  cfg_period_q <= cfg_wdata_i;
        CfgBeepOn:  cfg_on_q     <= cfg_wdata_i[7:0];
        CfgBeepOff: cfg_off_q    <= cfg_wdata_i[7:0];
        CfgGuard:   cfg_guard_q  <= cfg_wdata_i[7:0];
        CfgLamp:    cfg_lamp_q   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      run_q       <= OFF_S;
      digit_q     <= DigitNone;
      lvl_a_q     <= 1'b0;
      lvl_b_q     <= 1'b0;
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
      beep_q      <= BEEP_IDLE;
      beep_left_q <= '0;
      beep_ms_q   <= '0;
      period_q    <= '0;
      lamp_q      <= LampDark;
      lamp_ms_q   <= '0;
      since_q     <= 8'hFF;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      run_q       <= run_d;
      digit_q     <= digit_d;
      lvl_a_q     <= lvl_a_d;
      lvl_b_q     <= lvl_b_d;
      pend_a_q    <= pend_a_d;
      pend_b_q    <= pend_b_d;
      beep_q      <= beep_d;
      beep_left_q <= beep_left_d;
      beep_ms_q   <= beep_ms_d;
      period_q    <= period_d;
      lamp_q      <= lamp_d;
      lamp_ms_q   <= lamp_ms_d;
      since_q     <= since_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_count_q <= count_d;
      o_run_q   <= run_code(run_d);
      o_digit_q <= digit_d;
      o_beep_q  <= (beep_d == BEEP_ON);
      o_lamp_q  <= lamp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign count_value_o  = o_count_q;
  assign run_state_o    = o_run_q;
  assign adjust_digit_o = o_digit_q;
  assign beeper_on_o    = o_beep_q;
  assign dir_lamp_o     = o_lamp_q;

endmodule

>>> rtl/core/countdown_timer_with_encoder_set.sv
// Top level of the four-digit countdown timer controller.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   events   | in_valid_i/in_stall_o, cmd_i, pin_level_i  | in
//   results  | out_valid_o/out_stall_i, count_value_o,    | out
//            | run_state_o, adjust_digit_o, beeper_on_o,  |
//            | dir_lamp_o                                 |
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i           | in
//
// One beat per cycle sustained while the result side is not stalled; each taken
// beat is written into the event queue, then the executor pops it and updates
// its state and the result register on the same edge.
// in_stall_o rises only when the QDEPTH-entry event queue is full.
// A stalled result holds in the output register while new beats fill the event queue.
// Reset is asynchronous: timer off, count zero, config registers at their defaults.
module countdown_timer_with_encoder_set #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] count_value_o,
  output logic [1:0]  run_state_o,
  output logic [2:0]  adjust_digit_o,
  output logic        beeper_on_o,
  output logic [1:0]  dir_lamp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i
);
  import cdt_pkg::*;

  logic push, full, pop, q_valid;
  ev_t  ev_in, ev_out;

  cdt_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .pin_level_i (pin_level_i),
    .full_i      (full),
    .push_o      (push),
    .ev_o        (ev_in)
  );

  cdt_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (ev_in),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (ev_out)
  );

  cdt_exec u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ev_valid_i     (q_valid),
    .ev_i           (ev_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .count_value_o  (count_value_o),
    .run_state_o    (run_state_o),
    .adjust_digit_o (adjust_digit_o),
    .beeper_on_o    (beeper_on_o),
    .dir_lamp_o     (dir_lamp_o)
  );

endmodule

>>> rtl/core/cdt_checker.sv
// Port-level checks for the countdown timer, bound to the top level.
module cdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [13:0] count_value_o,
  input logic [1:0]  run_state_o,
  input logic [2:0]  adjust_digit_o,
  input logic        beeper_on_o,
  input logic [1:0]  dir_lamp_o
);
  import cdt_pkg::*;

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_value_o) &&
    $stable(run_state_o) && $stable(adjust_digit_o) && $stable(beeper_on_o) &&
    $stable(dir_lamp_o))
    else $error("result changed while stalled");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_value_o <= MaxCount && adjust_digit_o <= DigitNone &&
    dir_lamp_o != 2'd3)
    else $error("result field out of range");

  // start deselects the digit and needs a nonzero count; reaching zero stops
  a_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_state_o == RsRun |->
    adjust_digit_o == DigitNone && count_value_o != 14'd0)
    else $error("running with a digit selected or at zero");

  a_off_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_state_o == RsOff |-> adjust_digit_o == DigitNone)
    else $error("off with a digit selected");

endmodule

bind countdown_timer_with_encoder_set cdt_checker u_cdt_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the countdown timer controller with encoder digit setting.
module testbench;
  import cdt_pkg::*;

  // event and config codes the block must ignore
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam logic [2:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic [13:0] count;
    logic [1:0]  run;
    logic [2:0]  digit;
    logic        beep;
    logic [1:0]  lamp;
  } status_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       lvl;
    logic       pinned;
    status_t    want;
  } stim_row_t;

  typedef enum logic [1:0] {TONE_ON, TONE_GAP, TONE_IDLE} tone_e;

  localparam status_t FromModel = '0;
  localparam status_t IdleOff = '{14'd0, RsOff, DigitNone, 1'b0, LampDark};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = CmdTick;
  logic        pin_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [13:0] count_value_o;
  logic [1:0]  run_state_o;
  logic [2:0]  adjust_digit_o;
  logic        beeper_on_o;
  logic [1:0]  dir_lamp_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CfgPeriod;
  logic [9:0]  cfg_wdata_i = 10'd0;

  countdown_timer_with_encoder_set DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // predicted timer state and settings
  logic [9:0]  cfg_period;
  logic [7:0]  cfg_on, cfg_off, cfg_guard, cfg_lamp;
  logic [13:0] count_q;
  logic [1:0]  run_q;
  logic [2:0]  digit_q;
  logic        lvl_a, lvl_b, a_armed, b_armed;
  tone_e       tone;
  logic [2:0]  tone_left;
  logic [7:0]  tone_ms;
  logic [9:0]  period_cnt;
  logic [1:0]  lamp_q;
  logic [7:0]  lamp_ms;
  logic [7:0]  since_push;

  status_t status_due[$];
  bit      pin_on = 1'b0;
  status_t pin_want;
  int      faults = 0;
  int      items_sent = 0;
  int      sink_wait = 0;
  bit      calm = 1'b0;

  task automatic reset_model();
    cfg_period = 10'd2;
    cfg_on = 8'd200;
    cfg_off = 8'd200;
    cfg_guard = 8'd50;
    cfg_lamp = 8'd100;
    count_q = '0;
    run_q = RsOff;
    digit_q = DigitNone;
    lvl_a = 1'b0;
    lvl_b = 1'b0;
    a_armed = 1'b0;
    b_armed = 1'b0;
    tone = TONE_IDLE;
    tone_left = '0;
    tone_ms = '0;
    period_cnt = '0;
    lamp_q = LampDark;
    lamp_ms = '0;
    since_push = 8'd255;
  endtask

  task automatic start_tone(input logic [2:0] pulses);
    tone_left = pulses;
    tone = TONE_ON;
    tone_ms = '0;
  endtask

  task automatic step_run_state();
    case (run_q)
      RsRun: begin
        run_q = RsStop;
        start_tone(3'd1);
      end
      RsStop: begin
        if (count_q != 0) begin
          run_q = RsClear;
          count_q = '0;
        end else begin
          digit_q = DigitNone;
          run_q = RsOff;
        end
        start_tone(3'd1);
      end
      RsClear: begin
        digit_q = DigitNone;
        run_q = RsOff;
        start_tone(3'd1);
      end
      default: ;
    endcase
  endtask

  task automatic encoder_move(input bit up);
    logic [13:0] w;
    lamp_q = up ? LampUp : LampDown;
    lamp_ms = '0;
    if (digit_q < DigitNone) begin
      case (digit_q)
        3'd0:    w = 14'd1000;
        3'd1:    w = 14'd100;
        3'd2:    w = 14'd10;
        default: w = 14'd1;
      endcase
      if (up) begin
        if (count_q + w <= MaxCount) count_q = count_q + w;
      end else if (count_q >= w) begin
        count_q = count_q - w;
      end
    end
    if (run_q == RsRun) step_run_state();
    run_q = RsStop;
  endtask

  task automatic apply_event(input logic [2:0] cmd, input logic lvl, output status_t st);
    int lim;
    case (cmd)
      CmdTick: begin
        if (since_push != 8'd255) since_push = since_push + 8'd1;
        if (run_q == RsRun) begin
          if (count_q == 0) begin
            run_q = RsStop;
            start_tone(3'd4);
          end else begin
            period_cnt = period_cnt + 10'd1;
            lim = (cfg_period == 0) ? 1 : cfg_period;
            if (period_cnt >= lim) begin
              period_cnt = '0;
              count_q = count_q - 14'd1;
              if (count_q == 0) begin
                run_q = RsStop;
                start_tone(3'd4);
              end
            end
          end
        end
        if (tone == TONE_ON) begin
          tone_ms = tone_ms + 8'd1;
          lim = (cfg_on == 0) ? 1 : cfg_on;
          if (tone_ms >= lim) begin
            tone_ms = '0;
            tone_left = tone_left - 3'd1;
            tone = (tone_left == 0) ? TONE_IDLE : TONE_GAP;
          end
        end else if (tone == TONE_GAP) begin
          tone_ms = tone_ms + 8'd1;
          lim = (cfg_off == 0) ? 1 : cfg_off;
          if (tone_ms >= lim) begin
            tone_ms = '0;
            tone = TONE_ON;
          end
        end
        if (lamp_q != LampDark) begin
          lamp_ms = lamp_ms + 8'd1;
          lim = (cfg_lamp == 0) ? 1 : cfg_lamp;
          if (lamp_ms >= lim) begin
            lamp_ms = '0;
            lamp_q = LampDark;
          end
        end
      end
      CmdStop: if (!lvl) step_run_state();
      CmdStart: begin
        if (!lvl && run_q != RsRun && count_q != 0) begin
          digit_q = DigitNone;
          period_cnt = '0;
          run_q = RsRun;
          start_tone(3'd1);
        end
      end
      CmdPush: begin
        if (since_push >= cfg_guard && !lvl && (run_q == RsStop || run_q == RsClear))
          digit_q = (digit_q >= DigitNone) ? 3'd0 : digit_q + 3'd1;
        since_push = '0;
      end
      CmdEdgeA: begin
        lvl_a = lvl;
        if (b_armed) begin
          if (lvl_a == lvl_b) begin
            encoder_move(1'b0);
            a_armed = 1'b0;
            b_armed = 1'b0;
          end else begin
            b_armed = 1'b0;
            a_armed = 1'b1;
          end
        end else begin
          a_armed = 1'b1;
        end
      end
      CmdEdgeB: begin
        lvl_b = lvl;
        if (a_armed) begin
          if (lvl_a == lvl_b) begin
            encoder_move(1'b1);
            a_armed = 1'b0;
            b_armed = 1'b0;
          end else begin
            a_armed = 1'b0;
            b_armed = 1'b1;
          end
        end else begin
          b_armed = 1'b1;
        end
      end
      default: ;
    endcase
    st = '{count_q, run_q, digit_q, tone == TONE_ON, lamp_q};
  endtask

  task automatic log_fault(input string what, input status_t want, input status_t got);
    faults++;
    if (faults <= 10)
      $display("%0t %s: want count=%0d run=%0d digit=%0d beep=%0b lamp=%0d", $time, what,
               want.count, want.run, want.digit, want.beep, want.lamp);
    if (faults <= 10)
      $display("%0t %s: got  count=%0d run=%0d digit=%0d beep=%0b lamp=%0d", $time, what,
               got.count, got.run, got.digit, got.beep, got.lamp);
  endtask

  // monitors: result beats are checked, then accepted events are predicted
  always @(posedge clk_i) begin : watch
    status_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{count_value_o, run_state_o, adjust_digit_o, beeper_on_o, dir_lamp_o};
      sink_wait = calm ? 0 : $urandom_range(0, 4);
      if (status_due.size() == 0) begin
        log_fault("unexpected beat", FromModel, got);
      end else begin
        want = status_due.pop_front();
        if (got.count !== want.count || got.run !== want.run || got.digit !== want.digit ||
            got.beep !== want.beep || got.lamp !== want.lamp)
          log_fault("mismatch", want, got);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      apply_event(cmd_i, pin_level_i, want);
      if (pin_on) begin
        want = pin_want;
        pin_on = 1'b0;
      end
      status_due.push_back(want);
    end
  end

  always @(negedge clk_i) begin
    if (sink_wait != 0) begin
      out_stall_i = 1'b1;
      sink_wait--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_event(input logic [2:0] cmd, input logic lvl);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    pin_level_i = lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    case (idx)
      CfgPeriod:  cfg_period = val;
      CfgBeepOn:  cfg_on = val[7:0];
      CfgBeepOff: cfg_off = val[7:0];
      CfgGuard:   cfg_guard = val[7:0];
      CfgLamp:    cfg_lamp = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [9:0] period, input logic [9:0] on_ms,
                               input logic [9:0] off_ms, input logic [9:0] guard,
                               input logic [9:0] lamp);
    settle();
    write_reg(CfgPeriod, period);
    write_reg(CfgBeepOn, on_ms);
    write_reg(CfgBeepOff, off_ms);
    write_reg(CfgGuard, guard);
    write_reg(CfgLamp, lamp);
    cfg_we_i = 1'b0;
  endtask

  // mostly operator-like sequences: encoder detents, button press/release, tick runs
  task automatic random_traffic(input int n);
    int stop_at, pick, reps;
    logic lvl;
    bit up;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      lvl = 1'($urandom_range(0, 1));
      if (pick < 30) begin
        up = ($urandom_range(0, 9) < 6);
        if (up) begin
          send_event(CmdEdgeA, lvl);
          send_event(CmdEdgeB, lvl);
        end else begin
          send_event(CmdEdgeB, lvl);
          send_event(CmdEdgeA, lvl);
        end
      end else if (pick < 45) begin
        send_event(CmdPush, 1'b0);
        if ($urandom_range(0, 1)) send_event(CmdPush, 1'b1);
      end else if (pick < 55) begin
        send_event(CmdStart, 1'b0);
        send_event(CmdStart, 1'b1);
      end else if (pick < 65) begin
        send_event(CmdStop, 1'b0);
        send_event(CmdStop, 1'b1);
      end else if (pick < 90) begin
        reps = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 40);
        // long tick runs are cut at the end of this batch
        if (reps > stop_at - items_sent) reps = stop_at - items_sent;
        repeat (reps) send_event(CmdTick, 1'b0);
      end else begin
        repeat ($urandom_range(1, 3))
          send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    stim_row_t dir_plan [26];
    int n;
    dir_plan = '{
      '{CmdTick,   1'b0, 1'b1, IdleOff},
      '{CmdSpare6, 1'b1, 1'b1, IdleOff},
      '{CmdSpare7, 1'b0, 1'b1, IdleOff},
      '{CmdStart,  1'b0, 1'b1, IdleOff},
      '{CmdStop,   1'b0, 1'b1, IdleOff},
      '{CmdEdgeA,  1'b1, 1'b1, IdleOff},
      // completed detent forces stopped even from off
      '{CmdEdgeB,  1'b1, 1'b1, '{14'd0, RsStop, DigitNone, 1'b0, LampUp}},
      '{CmdPush,   1'b0, 1'b1, '{14'd0, RsStop, 3'd0, 1'b0, LampUp}},
      // second push inside the guard window
      '{CmdPush,   1'b0, 1'b1, '{14'd0, RsStop, 3'd0, 1'b0, LampUp}},
      '{CmdEdgeB,  1'b0, 1'b0, FromModel},
      // decrement below zero is dropped
      '{CmdEdgeA,  1'b0, 1'b1, '{14'd0, RsStop, 3'd0, 1'b0, LampDown}},
      '{CmdEdgeA,  1'b1, 1'b0, FromModel},
      '{CmdEdgeB,  1'b1, 1'b1, '{14'd1000, RsStop, 3'd0, 1'b0, LampUp}},
      // unequal levels: newer edge takes over as pending
      '{CmdEdgeB,  1'b0, 1'b0, FromModel},
      '{CmdEdgeA,  1'b1, 1'b0, FromModel},
      '{CmdEdgeB,  1'b1, 1'b0, FromModel},
      '{CmdStart,  1'b1, 1'b0, FromModel},
      '{CmdStart,  1'b0, 1'b1, '{14'd2000, RsRun, DigitNone, 1'b1, LampUp}},
      '{CmdTick,   1'b0, 1'b0, FromModel},
      '{CmdTick,   1'b0, 1'b0, FromModel},
      '{CmdEdgeA,  1'b0, 1'b0, FromModel},
      '{CmdEdgeB,  1'b0, 1'b0, FromModel},
      '{CmdStop,   1'b0, 1'b0, FromModel},
      '{CmdStop,   1'b0, 1'b0, FromModel},
      '{CmdStop,   1'b0, 1'b0, FromModel},
      '{CmdStop,   1'b1, 1'b0, FromModel}
    };
    reset_model();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_plan[i]) begin
      pin_on = dir_plan[i].pinned;
      pin_want = dir_plan[i].want;
      send_event(dir_plan[i].cmd, dir_plan[i].lvl);
    end
    random_traffic(150);

    load_settings(10'd1, 10'd1, 10'd1, 10'd0, 10'd1);
    random_traffic(180);
    load_settings(10'd1000, 10'd255, 10'd255, 10'd255, 10'd255);
    random_traffic(180);
    // zero in the period, beep and lamp registers behaves as one
    load_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    random_traffic(160);
    // upper data bits fall off the 8-bit registers
    load_settings(10'h3FF, 10'h305, 10'h2C3, 10'h1FF, 10'h30A);
    write_reg(CfgUnused, 10'h3FF);
    cfg_we_i = 1'b0;
    random_traffic(160);
    repeat (3) begin
      load_settings(10'($urandom_range(1, 6)), 10'($urandom_range(1, 20)),
                    10'($urandom_range(1, 20)), 10'($urandom_range(0, 60)),
                    10'($urandom_range(1, 40)));
      random_traffic(160);
    end

    in_valid_i = 1'b0;
    n = 0;
    while (status_due.size() != 0 && n < 2000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (8) @(negedge clk_i);
    if (faults == 0 && status_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cdt_pkg.sv
rtl/core/cdt_front.sv
rtl/core/cdt_queue.sv
rtl/core/cdt_exec.sv
rtl/core/countdown_timer_with_encoder_set.sv
rtl/core/cdt_checker.sv
tb/sv/testbench.sv
